// ===== rtl/ppi_pkg.sv =====
// Shared types, constants and helper functions for the point projection pipeline.
package ppi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ROT_FRAC  = 19;
    localparam int ROT_W     = 21;
    localparam int NUM_REGS  = 8;
    localparam int ADDR_W    = 6;
    localparam int QW        = 33;          // quotient bits produced by the divider
    localparam int NW        = 65;          // rounded numerator width
    localparam int DIV_LAT   = QW + 1;

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        REG_ROT0   = 3'd0,
        REG_ROT1   = 3'd1,
        REG_ROT2   = 3'd2,
        REG_POS_XY = 3'd3,
        REG_POS_Z  = 3'd4,
        REG_FOCAL  = 3'd5,
        REG_CENTER = 3'd6,
        REG_SKEW   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [62:0]        rot0;
        logic [62:0]        rot1;
        logic [62:0]        rot2;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] sk;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic               sat;
    } t_cam;

    typedef struct packed {
        logic               valid;
        logic [NW-1:0]      num_u;
        logic [NW-1:0]      num_v;
        logic [31:0]        dmag;
        logic               neg_u;
        logic               neg_v;
        logic               zero;
        logic               sat;
        logic signed [31:0] c2;
    } t_num;

    function automatic logic [63:0] reg_reset(input t_reg_idx idx);
        logic [63:0] v;
        v = '0;
        unique case (idx)
            REG_ROT0:  v = 64'(1) << ROT_FRAC;
            REG_ROT1:  v = 64'(1) << (ROT_W + ROT_FRAC);
            REG_ROT2:  v = 64'(1) << (2 * ROT_W + ROT_FRAC);
            REG_FOCAL: v = {ONE, ONE};
            default:   v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] reg_mask(input t_reg_idx idx);
        logic [63:0] m;
        m = '1;
        unique case (idx)
            REG_ROT0, REG_ROT1, REG_ROT2: m = {1'b0, {63{1'b1}}};
            REG_POS_Z, REG_SKEW:          m = {32'd0, {32{1'b1}}};
            default:                      m = '1;
        endcase
        return m;
    endfunction

    // {clamped, value}: sign applied to a quotient magnitude, clamped to 32 bits
    function automatic logic [32:0] sat_quo(input logic [QW-1:0] q, input logic neg,
                                           input logic ovf);
        logic [32:0] r;
        r = '0;
        if (!neg) begin
            if (ovf || q > QW'(32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
            else                               r = {1'b0, q[31:0]};
        end else begin
            if (ovf || q > QW'(32'h8000_0000)) r = {1'b1, 32'h8000_0000};
            else                               r = {1'b0, 32'(-q)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/project_point_to_image.sv =====
// An accepted input word passes the transform, intrinsic and divider stages, then the output register.
// Throughput: one point per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Most of the pipeline depth lies in the two 34-stage divider pipelines for u and v.
// Reset (synchronous, active low) clears all valid bits and loads the registers
// with identity rotation, unit focal lengths and zero elsewhere.
module project_point_to_image (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [95:0]                i_s_axis_tdata,  // point_x, point_y, point_z
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [95:0]                o_m_axis_tdata,  // image_u, image_v, depth
    output logic [1:0]                 o_m_axis_tuser,  // zero_depth, saturated
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ppi_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);
    localparam int NL = ppi_pkg::DIV_LAT;

    ppi_pkg::t_cfg w_cfg;
    ppi_pkg::t_cam w_cam;
    ppi_pkg::t_num w_num;
    logic          w_en;
    logic [ppi_pkg::QW-1:0] w_qu, w_qv;
    logic          w_ovf_u, w_ovf_v;
    logic [32:0]   w_ru, w_rv;

    logic [NL-1:0]      r_sb_vld;
    logic [NL-1:0]      r_sb_neg_u, r_sb_neg_v, r_sb_zero, r_sb_sat;
    logic signed [31:0] r_sb_c2 [0:NL-1];
    logic               r_out_vld;
    logic [95:0]        r_out_data;
    logic [1:0]         r_out_user;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    ppi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ppi_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_px    (i_s_axis_tdata[31:0]),
        .i_py    (i_s_axis_tdata[63:32]),
        .i_pz    (i_s_axis_tdata[95:64]),
        .i_cfg   (w_cfg),
        .o_cam   (w_cam)
    );

    ppi_intr u_intr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cam   (w_cam),
        .i_cfg   (w_cfg),
        .o_num   (w_num)
    );

    ppi_div u_div_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num.num_u),
        .i_den (w_num.dmag),
        .o_quo (w_qu),
        .o_ovf (w_ovf_u)
    );

    ppi_div u_div_v (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num.num_v),
        .i_den (w_num.dmag),
        .o_quo (w_qv),
        .o_ovf (w_ovf_v)
    );

    // sideband travels alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_sb_vld  <= {r_sb_vld[NL-2:0], w_num.valid};
            r_out_vld <= r_sb_vld[NL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_neg_u <= {r_sb_neg_u[NL-2:0], w_num.neg_u};
            r_sb_neg_v <= {r_sb_neg_v[NL-2:0], w_num.neg_v};
            r_sb_zero  <= {r_sb_zero[NL-2:0], w_num.zero};
            r_sb_sat   <= {r_sb_sat[NL-2:0], w_num.sat};
            r_sb_c2[0] <= w_num.c2;
            for (int i = 1; i < NL; i++) begin
                r_sb_c2[i] <= r_sb_c2[i-1];
            end
        end
    end

    assign w_ru = ppi_pkg::sat_quo(w_qu, r_sb_neg_u[NL-1], w_ovf_u);
    assign w_rv = ppi_pkg::sat_quo(w_qv, r_sb_neg_v[NL-1], w_ovf_v);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_sb_zero[NL-1]) begin
                r_out_data <= {r_sb_c2[NL-1], 32'd0, 32'd0};
                r_out_user <= {r_sb_sat[NL-1], 1'b1};
            end else begin
                r_out_data <= {r_sb_c2[NL-1], w_rv[31:0], w_ru[31:0]};
                r_out_user <= {r_sb_sat[NL-1] | w_ru[32] | w_rv[32], 1'b0};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_zero_uv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        (o_m_axis_tdata[63:0] == 64'd0 && o_m_axis_tdata[95:64] == 32'd0))
        else $error("zero depth result with nonzero fields");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow pipeline advance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> ($stable(r_sb_vld) && $stable(r_out_data)))
        else $error("pipeline moved while stalled");
endmodule

// ===== rtl/ppi_regs.sv =====
// Configuration register file behind the APB-style port.
module ppi_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ppi_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    output ppi_pkg::t_cfg              o_cfg
);
    logic [63:0]       r_reg [0:ppi_pkg::NUM_REGS-1];
    ppi_pkg::t_reg_idx w_idx;

    assign w_idx  = ppi_pkg::t_reg_idx'(paddr[5:3]);
    assign pready = 1'b1;
    assign prdata = r_reg[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ppi_pkg::NUM_REGS; i++) begin
                r_reg[i] <= ppi_pkg::reg_reset(ppi_pkg::t_reg_idx'(i));
            end
        end else if (psel && penable && pwrite && pready) begin
            r_reg[w_idx] <= pwdata & ppi_pkg::reg_mask(w_idx);
        end
    end

    always_comb begin
        o_cfg.rot0  = r_reg[ppi_pkg::REG_ROT0][62:0];
        o_cfg.rot1  = r_reg[ppi_pkg::REG_ROT1][62:0];
        o_cfg.rot2  = r_reg[ppi_pkg::REG_ROT2][62:0];
        o_cfg.pos_x = r_reg[ppi_pkg::REG_POS_XY][31:0];
        o_cfg.pos_y = r_reg[ppi_pkg::REG_POS_XY][63:32];
        o_cfg.pos_z = r_reg[ppi_pkg::REG_POS_Z][31:0];
        o_cfg.fx    = r_reg[ppi_pkg::REG_FOCAL][31:0];
        o_cfg.fy    = r_reg[ppi_pkg::REG_FOCAL][63:32];
        o_cfg.cx    = r_reg[ppi_pkg::REG_CENTER][31:0];
        o_cfg.cy    = r_reg[ppi_pkg::REG_CENTER][63:32];
        o_cfg.sk    = r_reg[ppi_pkg::REG_SKEW][31:0];
    end
endmodule

// ===== rtl/ppi_xform.sv =====
// Translate and rotate stages: world point to rounded, clamped camera space.
module ppi_xform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  ppi_pkg::t_cfg      i_cfg,
    output ppi_pkg::t_cam      o_cam
);
    logic [2:0]         r_vld;
    logic signed [32:0] r_d [0:2];
    logic signed [53:0] r_p [0:8];
    logic signed [31:0] r_c [0:2];
    logic               r_sat;
    logic [62:0]        w_rot [0:2];
    logic signed [31:0] w_c [0:2];
    logic [2:0]         w_sat;

    assign w_rot[0] = i_cfg.rot0;
    assign w_rot[1] = i_cfg.rot1;
    assign w_rot[2] = i_cfg.rot2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // exact rotation sums, then round half up at 19 bits and clamp
    always_comb begin
        logic signed [55:0] s;
        logic signed [55:0] t;
        logic signed [36:0] c;
        for (int i = 0; i < 3; i++) begin
            s = {{2{r_p[3*i][53]}}, r_p[3*i]} + {{2{r_p[3*i+1][53]}}, r_p[3*i+1]}
              + {{2{r_p[3*i+2][53]}}, r_p[3*i+2]};
            t = s + 56'(1 << (ppi_pkg::ROT_FRAC - 1));
            c = t[55:ppi_pkg::ROT_FRAC];
            if (c[36:31] != {6{c[31]}}) begin
                w_sat[i] = 1'b1;
                w_c[i]   = c[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                w_sat[i] = 1'b0;
                w_c[i]   = c[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= {i_px[31], i_px} - {i_cfg.pos_x[31], i_cfg.pos_x};
            r_d[1] <= {i_py[31], i_py} - {i_cfg.pos_y[31], i_cfg.pos_y};
            r_d[2] <= {i_pz[31], i_pz} - {i_cfg.pos_z[31], i_cfg.pos_z};
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[3*i+j] <= $signed(w_rot[i][ppi_pkg::ROT_W*j +: ppi_pkg::ROT_W])
                                * r_d[j];
                end
            end
            r_c[0] <= w_c[0];
            r_c[1] <= w_c[1];
            r_c[2] <= w_c[2];
            r_sat  <= |w_sat;
        end
    end

    assign o_cam.valid = r_vld[2];
    assign o_cam.c0    = r_c[0];
    assign o_cam.c1    = r_c[1];
    assign o_cam.c2    = r_c[2];
    assign o_cam.sat   = r_sat;
endmodule

// ===== rtl/ppi_intr.sv =====
// Intrinsic stages: numerators for u and v, signs and rounded magnitudes.
module ppi_intr (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  ppi_pkg::t_cam i_cam,
    input  ppi_pkg::t_cfg i_cfg,
    output ppi_pkg::t_num o_num
);
    logic [2:0]         r_vld;
    logic signed [63:0] r_pu0, r_pu1, r_pu2, r_pv1, r_pv2;
    logic signed [31:0] r_c2_a, r_c2_b, r_c2_c;
    logic               r_sat_a, r_sat_b, r_sat_c;
    logic [63:0]        r_mag_u, r_mag_v;
    logic [31:0]        r_dmag_b, r_dmag_c;
    logic               r_neg_u_b, r_neg_v_b, r_neg_u_c, r_neg_v_c;
    logic               r_zero_b, r_zero_c;
    logic [ppi_pkg::NW-1:0] r_num_u, r_num_v;
    logic signed [64:0] w_su, w_sv, w_au, w_av;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_cam.valid};
        end
    end

    always_comb begin
        w_su = {r_pu0[63], r_pu0} + {r_pu1[63], r_pu1} + {r_pu2[63], r_pu2};
        w_sv = {r_pv1[63], r_pv1} + {r_pv2[63], r_pv2};
        w_au = w_su[64] ? -w_su : w_su;
        w_av = w_sv[64] ? -w_sv : w_sv;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pu0   <= i_cfg.fx * i_cam.c0;
            r_pu1   <= i_cfg.sk * i_cam.c1;
            r_pu2   <= i_cfg.cx * i_cam.c2;
            r_pv1   <= i_cfg.fy * i_cam.c1;
            r_pv2   <= i_cfg.cy * i_cam.c2;
            r_c2_a  <= i_cam.c2;
            r_sat_a <= i_cam.sat;

            r_mag_u   <= w_au[63:0];
            r_mag_v   <= w_av[63:0];
            r_neg_u_b <= w_su[64] ^ r_c2_a[31];
            r_neg_v_b <= w_sv[64] ^ r_c2_a[31];
            r_dmag_b  <= r_c2_a[31] ? 32'(-r_c2_a) : 32'(r_c2_a);
            r_zero_b  <= (r_c2_a == 32'sd0);
            r_c2_b    <= r_c2_a;
            r_sat_b   <= r_sat_a;

            // half the divisor folded in gives round half away from zero
            r_num_u   <= {1'b0, r_mag_u} + ppi_pkg::NW'(r_dmag_b[31:1]);
            r_num_v   <= {1'b0, r_mag_v} + ppi_pkg::NW'(r_dmag_b[31:1]);
            r_dmag_c  <= r_dmag_b;
            r_neg_u_c <= r_neg_u_b;
            r_neg_v_c <= r_neg_v_b;
            r_zero_c  <= r_zero_b;
            r_c2_c    <= r_c2_b;
            r_sat_c   <= r_sat_b;
        end
    end

    assign o_num.valid = r_vld[2];
    assign o_num.num_u = r_num_u;
    assign o_num.num_v = r_num_v;
    assign o_num.dmag  = r_dmag_c;
    assign o_num.neg_u = r_neg_u_c;
    assign o_num.neg_v = r_neg_v_c;
    assign o_num.zero  = r_zero_c;
    assign o_num.sat   = r_sat_c;
    assign o_num.c2    = r_c2_c;
endmodule

// ===== rtl/ppi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module ppi_div (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [ppi_pkg::NW-1:0] i_num,
    input  logic [31:0]            i_den,
    output logic [ppi_pkg::QW-1:0] o_quo,
    output logic                   o_ovf
);
    localparam int NS = ppi_pkg::DIV_LAT;

    logic [31:0]              r_rem [0:NS-1];
    logic [ppi_pkg::QW-1:0]   r_low [0:NS-1];
    logic [ppi_pkg::QW-1:0]   r_q   [0:NS-1];
    logic [31:0]              r_den [0:NS-1];
    logic [NS-1:0]            r_ovf;

    // quotient needs more than QW bits when the top part already reaches the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[ppi_pkg::NW-1:ppi_pkg::QW];
            r_low[0] <= i_num[ppi_pkg::QW-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= (i_num[ppi_pkg::NW-1:ppi_pkg::QW] >= i_den);
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_stage
        logic [32:0] w_t;
        logic        w_ge;
        assign w_t  = {r_rem[s-1], r_low[s-1][ppi_pkg::QW-1]};
        assign w_ge = (w_t >= {1'b0, r_den[s-1]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? 32'(w_t - {1'b0, r_den[s-1]}) : w_t[31:0];
                r_low[s] <= {r_low[s-1][ppi_pkg::QW-2:0], 1'b0};
                r_q[s]   <= {r_q[s-1][ppi_pkg::QW-2:0], w_ge};
                r_den[s] <= r_den[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    assign o_quo = r_q[NS-1];
    assign o_ovf = r_ovf[NS-1];
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the point-to-image projection pipeline.
module tb_top;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] depth;
        logic               zero;
        logic               sat;
    } t_proj;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [95:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [95:0] m_data;
    logic [1:0]  m_user;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ppi_pkg::ADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    logic [63:0] cam_regs [ppi_pkg::NUM_REGS];
    t_proj       proj_q[$];
    int          n_fail = 0;
    int          n_points = 0;
    int          n_results = 0;
    int          n_zero = 0;
    int          n_sat = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_cycles = 0;

    project_point_to_image u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [71:0] x,
                                                   inout logic flag);
        if (x > 72'sh7FFF_FFFF) begin
            flag = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (x < -72'sh8000_0000) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

    // signed quotient, nearest with ties away from zero, then clamped
    function automatic logic signed [31:0] div_round(input logic signed [71:0] num,
                                                     input logic signed [31:0] den,
                                                     inout logic flag);
        logic [71:0] mag, dm, q;
        logic        neg;
        neg = num[71] ^ den[31];
        mag = num[71] ? -num : num;
        dm  = den[31] ? 72'(-73'(den)) : 72'(den);
        q   = (mag + dm / 2) / dm;
        return clamp32(neg ? -$signed(q) : $signed(q), flag);
    endfunction

    function automatic t_proj project(input logic [95:0] pt);
        logic signed [33:0] d [3];
        logic signed [71:0] acc, t;
        logic signed [31:0] c [3];
        logic signed [20:0] r;
        logic        flag;
        t_proj       res;
        flag = 1'b0;
        d[0] = $signed(pt[31:0]) - $signed(cam_regs[ppi_pkg::REG_POS_XY][31:0]);
        d[1] = $signed(pt[63:32]) - $signed(cam_regs[ppi_pkg::REG_POS_XY][63:32]);
        d[2] = $signed(pt[95:64]) - $signed(cam_regs[ppi_pkg::REG_POS_Z][31:0]);
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                r = cam_regs[i][21*j +: 21];
                acc += r * d[j];
            end
            t = (acc + (72'sd1 <<< (ppi_pkg::ROT_FRAC - 1))) >>> ppi_pkg::ROT_FRAC;
            c[i] = clamp32(t, flag);
        end
        res.u = 0;
        res.v = 0;
        res.zero = (c[2] == 0);
        if (!res.zero) begin
            acc = $signed(cam_regs[ppi_pkg::REG_FOCAL][31:0]) * c[0]
                + $signed(cam_regs[ppi_pkg::REG_SKEW][31:0]) * c[1]
                + $signed(cam_regs[ppi_pkg::REG_CENTER][31:0]) * c[2];
            res.u = div_round(acc, c[2], flag);
            acc = $signed(cam_regs[ppi_pkg::REG_FOCAL][63:32]) * c[1]
                + $signed(cam_regs[ppi_pkg::REG_CENTER][63:32]) * c[2];
            res.v = div_round(acc, c[2], flag);
        end
        res.depth = c[2];
        res.sat = flag;
        return res;
    endfunction

    task automatic reg_write(input ppi_pkg::t_reg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ppi_pkg::ADDR_W'(8 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cam_regs[idx] = val & ppi_pkg::reg_mask(idx);
    endtask

    // valid stays up between back-to-back words; drain lowers it at the end
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input bit gaps);
        int g;
        g = 0;
        if (gaps) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        end
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {z, y, x};
        do @(posedge i_clk); while (!s_ready);
        proj_q.push_back(project({z, y, x}));
        n_points++;
    endtask

    // sink with random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_cycles <= 300;
            m_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_proj want;
        if (i_rst_n && m_valid && m_ready) begin
            n_results++;
            if (proj_q.size() == 0) begin
                $error("result word with nothing expected");
                n_fail++;
            end else begin
                want = proj_q.pop_front();
                if (m_user[0]) n_zero++;
                if (m_user[1]) n_sat++;
                if (m_data[31:0] !== want.u) begin
                    $error("image_u exp %h got %h", want.u, m_data[31:0]); n_fail++;
                end
                if (m_data[63:32] !== want.v) begin
                    $error("image_v exp %h got %h", want.v, m_data[63:32]); n_fail++;
                end
                if (m_data[95:64] !== want.depth) begin
                    $error("depth exp %h got %h", want.depth, m_data[95:64]); n_fail++;
                end
                if (m_user[0] !== want.zero) begin
                    $error("zero_depth exp %b got %b", want.zero, m_user[0]); n_fail++;
                end
                if (m_user[1] !== want.sat) begin
                    $error("saturated exp %b got %b", want.sat, m_user[1]); n_fail++;
                end
            end
        end
    end

    task automatic drain;
        s_valid <= 1'b0;
        while (proj_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    function automatic logic [20:0] rnd_rot();
        case ($urandom_range(0, 3))
            0: return 21'($urandom());
            1: return $urandom_range(0, 1) ? 21'h0F_FFFF : 21'h10_0000;
            default: return 21'($signed($urandom_range(0, 1048576)) - 524288);
        endcase
    endfunction

    task automatic test_directed;
        logic [31:0] ext [4];
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000};
        foreach (ext[i]) send_point(ext[i], ext[i], ext[i], 1'b0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0, 1'b0);       // zero divisor
        send_point(32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0); // u,v overflow
        send_point(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0003, 1'b0); // round tie area
        drain();
        // camera offset pushes d beyond 32 bits and c past its range
        reg_write(ppi_pkg::REG_POS_XY, {32'h8000_0000, 32'h8000_0000});
        reg_write(ppi_pkg::REG_POS_Z, 64'h8000_0000);
        reg_write(ppi_pkg::REG_ROT2, {1'b0, 21'h0F_FFFF, 21'h10_0000, 21'h0F_FFFF});
        for (int i = 0; i < 6; i++) send_point(ext[i % 4], ext[(i + 1) % 4], ext[i % 2], 1'b0);
        drain();
    endtask

    task automatic test_random_configs;
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(ppi_pkg::REG_ROT0, {1'b0, rnd_rot(), rnd_rot(), rnd_rot()});
            reg_write(ppi_pkg::REG_ROT1, {1'b0, rnd_rot(), rnd_rot(), rnd_rot()});
            reg_write(ppi_pkg::REG_ROT2, {1'b0, rnd_rot(), rnd_rot(), rnd_rot()});
            reg_write(ppi_pkg::REG_POS_XY, {rnd_coord(), rnd_coord()});
            reg_write(ppi_pkg::REG_POS_Z, {$urandom(), rnd_coord()});
            reg_write(ppi_pkg::REG_FOCAL, {rnd_coord(), rnd_coord()});
            reg_write(ppi_pkg::REG_CENTER, {rnd_coord(), rnd_coord()});
            reg_write(ppi_pkg::REG_SKEW, {$urandom(), rnd_coord()});
            if (ph == 0) begin
                for (int r = 0; r < ppi_pkg::NUM_REGS; r++)
                    reg_write(ppi_pkg::t_reg_idx'(r), '1);
            end else if (ph == 1) begin
                for (int r = 0; r < ppi_pkg::NUM_REGS; r++)
                    reg_write(ppi_pkg::t_reg_idx'(r), '0);
            end
            for (int i = 0; i < 117; i++) begin
                if (ph == 3 && i == 20) hold_req++;
                send_point(rnd_coord(), rnd_coord(), rnd_coord(), (ph % 4) != 2);
            end
            drain();
        end
    endtask

    initial begin
        for (int r = 0; r < ppi_pkg::NUM_REGS; r++)
            cam_regs[r] = ppi_pkg::reg_reset(ppi_pkg::t_reg_idx'(r));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_configs();
        $display("points %0d, results %0d (zero divisor %0d, clamped %0d)",
                 n_points, n_results, n_zero, n_sat);
        $display("covered reset setup, extremes, all registers and a long output stall");
        if (n_fail == 0 && proj_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ppi_pkg.sv
rtl/ppi_regs.sv
rtl/ppi_xform.sv
rtl/ppi_intr.sv
rtl/ppi_div.sv
rtl/project_point_to_image.sv
tb/sv/tb_top.sv
